// ----- sv/gdpt_pkg.sv -----
// Shared types, constants and saturating arithmetic helpers for the duality prune test core.
package gdpt_pkg;

    localparam int unsigned DATA_W      = 64;
    localparam int unsigned INDEX_W     = 16;
    localparam int unsigned S_TDATA_W   = 368;
    localparam int unsigned M_TDATA_W   = 72;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned DIV_STEPS   = 64;
    localparam int unsigned MID_STAGES  = 9;
    localparam int unsigned ROOT_STEPS  = 64;
    localparam int unsigned POST_STAGES = 11;

    typedef logic signed [DATA_W-1:0] q_t;

    localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_ORDER  = 2'd1,
        ST_DEGENERATE = 2'd2,
        ST_SATURATED  = 2'd3
    } status_t;

    typedef struct packed {
        logic sat;
        q_t   v;
    } satq_t;

    typedef struct packed {
        logic               bad;
        logic               sat;
        logic [INDEX_W-1:0] len;
        logic [INDEX_W-1:0] gap;
        q_t                 s_obj;
        q_t                 s_gap;
        q_t                 dq;
        q_t                 q_i;
    } work_t;

    function automatic satq_t sat_add(input q_t a, input q_t b);
        logic [DATA_W:0] s;
        satq_t r;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        r.sat = s[DATA_W] ^ s[DATA_W-1];
        r.v = r.sat ? (s[DATA_W] ? Q_MIN : Q_MAX) : q_t'(s[DATA_W-1:0]);
        return r;
    endfunction

    function automatic satq_t sat_sub(input q_t a, input q_t b);
        logic [DATA_W:0] s;
        satq_t r;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        r.sat = s[DATA_W] ^ s[DATA_W-1];
        r.v = r.sat ? (s[DATA_W] ? Q_MIN : Q_MAX) : q_t'(s[DATA_W-1:0]);
        return r;
    endfunction

    function automatic satq_t sat_neg(input q_t a);
        logic [DATA_W-1:0] u;
        satq_t r;
        u = a;
        r.sat = (a == Q_MIN);
        r.v = r.sat ? Q_MAX : q_t'(64'd0 - u);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] magnitude(input q_t x);
        logic [DATA_W-1:0] u;
        u = x;
        return u[DATA_W-1] ? (64'd0 - u) : u;
    endfunction

    function automatic satq_t pack_mag(input logic neg, input logic [127:0] mag);
        logic [127:0] limit;
        satq_t r;
        limit = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
        r.sat = (mag > limit);
        if (r.sat) begin
            r.v = neg ? Q_MIN : Q_MAX;
        end else begin
            r.v = neg ? q_t'(64'd0 - mag[63:0]) : q_t'(mag[63:0]);
        end
        return r;
    endfunction

    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        return a * b;
    endfunction

    function automatic logic [47:0] mul32x16(input logic [31:0] a, input logic [15:0] b);
        return a * b;
    endfunction

endpackage

// ----- sv/gaussian_duality_prune_test_core.sv -----
// Top level of the duality prune test core: input stage, queue and arithmetic pipeline.
//
// One input word carries the indices t, i, j, the cumulative sums at t, i, j and the
// costs at i and j; one output word carries the dual bound and a two-bit status
// (ok, bad index order, degenerate radicand, saturated).
// Throughput: one word per cycle while the output is not stalled. The arithmetic
// pipeline is fully staged: a 64-step restoring divider (one quotient bit per
// stage, three lanes), the Q products as 32x32 partial products, and a 64-step
// digit-by-digit square root.
// While an output word waits on m_tready the whole pipeline holds; the four-entry
// queue behind the input stage keeps s_tready high until it fills.
// Reset (aresetn low at a clock edge) empties the queue and the pipeline; words in
// flight are dropped.
module gaussian_duality_prune_test_core #(
    parameter int unsigned MAX_SERIES_LENGTH = 65536,
    parameter int unsigned FRACTION_BITS     = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // end_index, cursor_index, partner_index, cumsum_at_end, cumsum_at_cursor,
    // cumsum_at_partner, cost_at_cursor, cost_at_partner
    input  logic [gdpt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // dual_value, status, zero fill
    output logic [gdpt_pkg::M_TDATA_W-1:0] m_tdata
);

    logic            fr_valid, fr_ready;
    gdpt_pkg::work_t fr_item;
    logic            qu_valid, qu_ready;
    gdpt_pkg::work_t qu_item;

    gdpt_front #(
        .MAX_SERIES_LENGTH(MAX_SERIES_LENGTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    gdpt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (qu_valid),
        .out_ready (qu_ready),
        .out_item  (qu_item)
    );

    gdpt_back #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (qu_valid),
        .in_ready (qu_ready),
        .in_item  (qu_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[65:64] == gdpt_pkg::ST_BAD_ORDER
                     || m_tdata[65:64] == gdpt_pkg::ST_DEGENERATE)
        |-> m_tdata[63:0] == 64'd0)
        else $error("flagged word carries a nonzero value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> fr_valid && !fr_ready)
        else $error("input stalled without a held word");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// ----- sv/gdpt_front.sv -----
// Input stage: unpack a word, check index order, form lengths and saturated differences.
module gdpt_front #(
    parameter int unsigned MAX_SERIES_LENGTH = 65536
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gdpt_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output gdpt_pkg::work_t                     out_item
);

    logic            valid_reg;
    gdpt_pkg::work_t item_reg;
    gdpt_pkg::work_t item_next;

    logic [15:0]     t_idx, i_idx, j_idx;
    gdpt_pkg::q_t    cs_t, cs_i, cs_j, q_i, q_j;
    gdpt_pkg::satq_t s_obj, s_gap, s_dq;

    assign t_idx = s_tdata[15:0];
    assign i_idx = s_tdata[31:16];
    assign j_idx = s_tdata[47:32];
    assign cs_t  = s_tdata[111:48];
    assign cs_i  = s_tdata[175:112];
    assign cs_j  = s_tdata[239:176];
    assign q_i   = s_tdata[303:240];
    assign q_j   = s_tdata[367:304];

    always_comb begin
        s_obj = gdpt_pkg::sat_sub(cs_t, cs_i);
        s_gap = gdpt_pkg::sat_sub(cs_i, cs_j);
        s_dq  = gdpt_pkg::sat_sub(q_i, q_j);
        item_next.bad   = !(j_idx < i_idx && i_idx < t_idx)
                          || (32'(t_idx) >= 32'(MAX_SERIES_LENGTH));
        item_next.sat   = s_obj.sat | s_gap.sat | s_dq.sat;
        item_next.len   = t_idx - i_idx;
        item_next.gap   = i_idx - j_idx;
        item_next.s_obj = s_obj.v;
        item_next.s_gap = s_gap.v;
        item_next.dq    = s_dq.v;
        item_next.q_i   = q_i;
    end

    assign s_tready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- sv/gdpt_queue.sv -----
// Short queue between the input stage and the arithmetic pipeline.
module gdpt_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  gdpt_pkg::work_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output gdpt_pkg::work_t out_item
);

    gdpt_pkg::work_t                   mem_reg [gdpt_pkg::QUEUE_DEPTH];
    logic [gdpt_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [gdpt_pkg::QUEUE_PTR_W:0]    count_reg;
    logic                              push, pop;

    assign in_ready  = (count_reg != (gdpt_pkg::QUEUE_PTR_W + 1)'(gdpt_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- sv/gdpt_back.sv -----
// Arithmetic pipeline: length divisions, Q products, square root and the dual bound.
module gdpt_back #(
    parameter int unsigned FRACTION_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  gdpt_pkg::work_t                in_item,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gdpt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned MID_BASE  = gdpt_pkg::DIV_STEPS + 1;
    localparam int unsigned ROOT_BASE = MID_BASE + gdpt_pkg::MID_STAGES;
    localparam int unsigned POST_BASE = ROOT_BASE + gdpt_pkg::ROOT_STEPS;
    localparam int unsigned N_STAGES  = POST_BASE + gdpt_pkg::POST_STAGES + 1;

    typedef struct packed {
        logic              bad;
        logic              sat;
        logic [15:0]       len;
        logic [15:0]       gap;
        gdpt_pkg::q_t      q_i;
        logic [2:0]        neg;
        logic [2:0][63:0]  num;
        logic [2:0][15:0]  rem;
    } dctx_t;

    typedef struct packed {
        logic              bad;
        logic              sat_c;
        logic              sat_a;
        logic              sat_b;
        logic              take_a;
        logic              deg;
        logic [15:0]       len;
        gdpt_pkg::q_t      q_i;
        gdpt_pkg::q_t      m;
        gdpt_pkg::q_t      g;
        gdpt_pkg::q_t      cg;
        logic [63:0]       mq;
        logic [63:0]       gq;
        logic              m_neg;
        logic              g_neg;
        logic [11:0][63:0] pp;
        logic [2:0][127:0] prod;
        gdpt_pkg::q_t      msq;
        gdpt_pkg::q_t      mg;
        gdpt_pkg::q_t      gg;
        gdpt_pkg::q_t      mg2;
        gdpt_pkg::q_t      d;
        gdpt_pkg::q_t      rhs;
        gdpt_pkg::q_t      rad;
        gdpt_pkg::q_t      a;
        gdpt_pkg::q_t      h;
        gdpt_pkg::q_t      lm;
        gdpt_pkg::q_t      res_a;
    } mid_t;

    typedef struct packed {
        logic         bad;
        logic         deg;
        logic         take_a;
        logic         sat_a;
        logic         sat_b;
        logic [15:0]  len;
        gdpt_pkg::q_t q_i;
        gdpt_pkg::q_t res_a;
        gdpt_pkg::q_t h;
        gdpt_pkg::q_t a;
    } carry_t;

    typedef struct packed {
        logic [63:0]  root;
        logic [65:0]  rem;
        logic [127:0] v;
    } rstep_t;

    typedef struct packed {
        carry_t           c;
        gdpt_pkg::q_t     r;
        gdpt_pkg::q_t     left;
        gdpt_pkg::q_t     rt;
        logic [63:0]      lmag;
        logic [63:0]      rmag;
        logic             lneg;
        logic             rneg;
        logic [3:0][63:0] pp;
        logic [127:0]     prod;
        gdpt_pkg::q_t     lr;
        logic [63:0]      lrmag;
        logic             lrneg;
        gdpt_pkg::q_t     lm;
        gdpt_pkg::q_t     res_b;
    } post_t;

    function automatic gdpt_pkg::satq_t q_round(input logic neg, input logic [127:0] p);
        logic [127:0] t;
        t = p + (128'd1 << (FRACTION_BITS - 1));
        t = t >> FRACTION_BITS;
        return gdpt_pkg::pack_mag(neg, t);
    endfunction

    function automatic dctx_t div_load(input gdpt_pkg::work_t w);
        dctx_t y;
        y.bad    = w.bad;
        y.sat    = w.sat;
        y.len    = w.len;
        y.gap    = w.gap;
        y.q_i    = w.q_i;
        y.neg    = {w.dq[63], w.s_gap[63], w.s_obj[63]};
        y.num[0] = gdpt_pkg::magnitude(w.s_obj);
        y.num[1] = gdpt_pkg::magnitude(w.s_gap);
        y.num[2] = gdpt_pkg::magnitude(w.dq);
        y.rem    = '0;
        return y;
    endfunction

    function automatic dctx_t div_step(input dctx_t x);
        dctx_t       y;
        logic [16:0] t;
        logic [15:0] n;
        y = x;
        for (int l = 0; l < 3; l++) begin
            n = (l == 0) ? x.len : x.gap;
            t = {x.rem[l], x.num[l][63]};
            if (t >= {1'b0, n}) begin
                y.rem[l] = 16'(t - {1'b0, n});
                y.num[l] = {x.num[l][62:0], 1'b1};
            end else begin
                y.rem[l] = t[15:0];
                y.num[l] = {x.num[l][62:0], 1'b0};
            end
        end
        return y;
    endfunction

    function automatic mid_t mid_load(input dctx_t x);
        mid_t y;
        y       = '0;
        y.bad   = x.bad;
        y.sat_c = x.sat;
        y.len   = x.len;
        y.q_i   = x.q_i;
        y.mq    = x.num[0];
        y.gq    = x.num[1];
        y.m_neg = x.neg[0] & (|x.num[0]);
        y.g_neg = x.neg[1] & (|x.num[1]);
        y.m     = x.neg[0] ? gdpt_pkg::q_t'(64'd0 - x.num[0]) : gdpt_pkg::q_t'(x.num[0]);
        y.g     = x.neg[1] ? gdpt_pkg::q_t'(64'd0 - x.num[1]) : gdpt_pkg::q_t'(x.num[1]);
        y.cg    = x.neg[2] ? gdpt_pkg::q_t'(64'd0 - x.num[2]) : gdpt_pkg::q_t'(x.num[2]);
        return y;
    endfunction

    function automatic mid_t mid_step(input int unsigned k, input mid_t x);
        mid_t            y;
        gdpt_pkg::satq_t s0, s1, s2;
        logic [63:0]     fa, fb;
        y = x;
        case (k)
            1: begin
                for (int p = 0; p < 3; p++) begin
                    fa = (p == 2) ? x.gq : x.mq;
                    fb = (p == 0) ? x.mq : x.gq;
                    y.pp[4*p]   = gdpt_pkg::mul32(fa[31:0], fb[31:0]);
                    y.pp[4*p+1] = gdpt_pkg::mul32(fa[31:0], fb[63:32]);
                    y.pp[4*p+2] = gdpt_pkg::mul32(fa[63:32], fb[31:0]);
                    y.pp[4*p+3] = gdpt_pkg::mul32(fa[63:32], fb[63:32]);
                end
            end
            2: begin
                for (int p = 0; p < 3; p++) begin
                    y.prod[p] = 128'(x.pp[4*p]) + (128'(x.pp[4*p+1]) << 32)
                              + (128'(x.pp[4*p+2]) << 32) + (128'(x.pp[4*p+3]) << 64);
                end
            end
            3: begin
                s0 = q_round(1'b0, x.prod[0]);
                s1 = q_round(x.m_neg ^ x.g_neg, x.prod[1]);
                s2 = q_round(1'b0, x.prod[2]);
                y.msq   = s0.v;
                y.mg    = s1.v;
                y.gg    = s2.v;
                y.sat_c = x.sat_c | s0.sat | s1.sat;
                y.sat_b = x.sat_b | s2.sat;
            end
            4: begin
                s0 = gdpt_pkg::sat_add(x.mg, x.mg);
                s1 = gdpt_pkg::sat_sub(x.m, x.g);
                y.mg2   = s0.v;
                y.d     = s1.v;
                y.sat_c = x.sat_c | s0.sat;
                y.sat_b = x.sat_b | s1.sat;
            end
            5: begin
                s0 = gdpt_pkg::sat_sub(x.msq, x.mg2);
                s1 = gdpt_pkg::sat_add(x.cg, x.gg);
                y.rhs   = s0.v;
                y.rad   = s1.v;
                y.sat_c = x.sat_c | s0.sat;
                s2 = gdpt_pkg::sat_neg(x.d);
                y.a = x.d[63] ? s2.v : x.d;
                y.sat_b = x.sat_b | s1.sat | (x.d[63] & s2.sat);
                s2 = gdpt_pkg::sat_neg(x.g);
                y.h = x.d[63] ? s2.v : x.g;
                y.sat_b = y.sat_b | (x.d[63] & s2.sat);
            end
            6: begin
                y.take_a = ($signed(x.cg) <= $signed(x.rhs));
                y.deg    = !y.take_a && (x.rad[63] || (x.rad == '0));
                y.pp[0]  = 64'(gdpt_pkg::mul32x16(x.msq[31:0], x.len));
                y.pp[1]  = 64'(gdpt_pkg::mul32x16(x.msq[63:32], x.len));
            end
            7: begin
                s0 = gdpt_pkg::pack_mag(1'b0, 128'(x.pp[0]) + (128'(x.pp[1]) << 32));
                y.lm    = s0.v;
                y.sat_a = x.sat_a | s0.sat;
            end
            8: begin
                s0 = gdpt_pkg::sat_sub(x.q_i, x.lm);
                y.res_a = s0.v;
                y.sat_a = x.sat_a | x.sat_c | s0.sat;
                y.sat_b = x.sat_b | x.sat_c;
            end
            default: begin
                y = x;
            end
        endcase
        return y;
    endfunction

    function automatic carry_t carry_of(input mid_t x);
        carry_t c;
        c.bad    = x.bad;
        c.deg    = x.deg;
        c.take_a = x.take_a;
        c.sat_a  = x.sat_a;
        c.sat_b  = x.sat_b;
        c.len    = x.len;
        c.q_i    = x.q_i;
        c.res_a  = x.res_a;
        c.h      = x.h;
        c.a      = x.a;
        return c;
    endfunction

    function automatic rstep_t root_seed(input mid_t x);
        rstep_t y;
        logic   pos;
        pos    = !x.rad[63] && (x.rad != '0);
        y.root = '0;
        y.rem  = '0;
        y.v    = (pos ? {64'd0, 64'(x.rad)} : 128'd0) << FRACTION_BITS;
        return y;
    endfunction

    function automatic rstep_t root_step(input rstep_t x);
        rstep_t      y;
        logic [67:0] t;
        logic [67:0] trial;
        t     = {x.rem, x.v[127:126]};
        trial = {2'b00, x.root, 2'b01};
        if (t >= trial) begin
            y.rem  = 66'(t - trial);
            y.root = {x.root[62:0], 1'b1};
        end else begin
            y.rem  = t[65:0];
            y.root = {x.root[62:0], 1'b0};
        end
        y.v = x.v << 2;
        return y;
    endfunction

    function automatic post_t post_load(input carry_t c, input logic [63:0] root);
        post_t y;
        y   = '0;
        y.c = c;
        y.r = gdpt_pkg::q_t'(root);
        return y;
    endfunction

    function automatic post_t post_step(input int unsigned k, input post_t x);
        post_t           y;
        gdpt_pkg::satq_t s0, s1;
        y = x;
        case (k)
            1: begin
                s0 = gdpt_pkg::sat_add(x.r, x.c.h);
                s1 = gdpt_pkg::sat_sub(x.r, x.c.h);
                y.left    = s0.v;
                y.rt      = s1.v;
                y.c.sat_b = x.c.sat_b | s0.sat | s1.sat;
            end
            2, 3: begin
                s0 = gdpt_pkg::sat_sub(x.rt, x.c.a);
                y.rt      = s0.v;
                y.c.sat_b = x.c.sat_b | s0.sat;
            end
            4: begin
                y.lmag = gdpt_pkg::magnitude(x.left);
                y.rmag = gdpt_pkg::magnitude(x.rt);
                y.lneg = x.left[63];
                y.rneg = x.rt[63];
            end
            5: begin
                y.pp[0] = gdpt_pkg::mul32(x.lmag[31:0], x.rmag[31:0]);
                y.pp[1] = gdpt_pkg::mul32(x.lmag[31:0], x.rmag[63:32]);
                y.pp[2] = gdpt_pkg::mul32(x.lmag[63:32], x.rmag[31:0]);
                y.pp[3] = gdpt_pkg::mul32(x.lmag[63:32], x.rmag[63:32]);
            end
            6: begin
                y.prod = 128'(x.pp[0]) + (128'(x.pp[1]) << 32)
                       + (128'(x.pp[2]) << 32) + (128'(x.pp[3]) << 64);
            end
            7: begin
                s0 = q_round(x.lneg ^ x.rneg, x.prod);
                y.lr      = s0.v;
                y.c.sat_b = x.c.sat_b | s0.sat;
            end
            8: begin
                y.lrmag = gdpt_pkg::magnitude(x.lr);
                y.lrneg = x.lr[63];
            end
            9: begin
                y.pp[0] = 64'(gdpt_pkg::mul32x16(x.lrmag[31:0], x.c.len));
                y.pp[1] = 64'(gdpt_pkg::mul32x16(x.lrmag[63:32], x.c.len));
            end
            10: begin
                s0 = gdpt_pkg::pack_mag(x.lrneg, 128'(x.pp[0]) + (128'(x.pp[1]) << 32));
                y.lm      = s0.v;
                y.c.sat_b = x.c.sat_b | s0.sat;
            end
            11: begin
                s0 = gdpt_pkg::sat_add(x.c.q_i, x.lm);
                y.res_b   = s0.v;
                y.c.sat_b = x.c.sat_b | s0.sat;
            end
            default: begin
                y = x;
            end
        endcase
        return y;
    endfunction

    logic [N_STAGES-1:0] vld_reg;
    logic                en;

    dctx_t            d_reg    [0:gdpt_pkg::DIV_STEPS];
    mid_t             mid_reg  [0:gdpt_pkg::MID_STAGES-1];
    rstep_t           rs_reg   [0:gdpt_pkg::ROOT_STEPS-1];
    carry_t           rc_reg   [0:gdpt_pkg::ROOT_STEPS-1];
    post_t            post_reg [0:gdpt_pkg::POST_STAGES-1];
    gdpt_pkg::q_t     dual_reg, dual_next;
    gdpt_pkg::status_t status_reg, status_next;
    post_t            fin;

    assign en       = !vld_reg[N_STAGES-1] || m_tready;
    assign in_ready = en;
    assign m_tvalid = vld_reg[N_STAGES-1];
    assign m_tdata  = {6'd0, status_reg, dual_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0]    <= div_load(in_item);
            mid_reg[0]  <= mid_load(d_reg[gdpt_pkg::DIV_STEPS]);
            rs_reg[0]   <= root_step(root_seed(mid_reg[gdpt_pkg::MID_STAGES-1]));
            rc_reg[0]   <= carry_of(mid_reg[gdpt_pkg::MID_STAGES-1]);
            post_reg[0] <= post_step(1, post_load(rc_reg[gdpt_pkg::ROOT_STEPS-1],
                                                  rs_reg[gdpt_pkg::ROOT_STEPS-1].root));
        end
    end

    for (genvar k = 0; k < gdpt_pkg::DIV_STEPS; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k+1] <= div_step(d_reg[k]);
            end
        end
    end

    for (genvar k = 1; k < gdpt_pkg::MID_STAGES; k++) begin : g_mid
        always_ff @(posedge aclk) begin
            if (en) begin
                mid_reg[k] <= mid_step(k, mid_reg[k-1]);
            end
        end
    end

    for (genvar k = 1; k < gdpt_pkg::ROOT_STEPS; k++) begin : g_root
        always_ff @(posedge aclk) begin
            if (en) begin
                rs_reg[k] <= root_step(rs_reg[k-1]);
                rc_reg[k] <= rc_reg[k-1];
            end
        end
    end

    for (genvar k = 1; k < gdpt_pkg::POST_STAGES; k++) begin : g_post
        always_ff @(posedge aclk) begin
            if (en) begin
                post_reg[k] <= post_step(k + 1, post_reg[k-1]);
            end
        end
    end

    assign fin = post_reg[gdpt_pkg::POST_STAGES-1];

    always_comb begin
        if (fin.c.bad) begin
            dual_next   = '0;
            status_next = gdpt_pkg::ST_BAD_ORDER;
        end else if (fin.c.take_a) begin
            dual_next   = fin.c.res_a;
            status_next = fin.c.sat_a ? gdpt_pkg::ST_SATURATED : gdpt_pkg::ST_OK;
        end else if (fin.c.deg) begin
            dual_next   = '0;
            status_next = gdpt_pkg::ST_DEGENERATE;
        end else begin
            dual_next   = fin.res_b;
            status_next = fin.c.sat_b ? gdpt_pkg::ST_SATURATED : gdpt_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dual_reg   <= dual_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- sim/gaussian_duality_prune_test_core_tb.sv -----
// Self-checking testbench for the duality prune test core: directed and random words.
`timescale 1ns / 1ps

module gaussian_duality_prune_test_core_tb;

    localparam int unsigned FB      = 24;
    localparam int unsigned MAX_LEN = 65536;
    localparam int unsigned WDOG    = 20000;

    typedef struct {
        logic signed [63:0] value;
        gdpt_pkg::status_t  status;
    } bound_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gdpt_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [gdpt_pkg::M_TDATA_W-1:0] m_tdata;

    bound_t      bound_q[$];
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    bit          calm = 1'b0;
    bit          hold_sink = 1'b0;

    gaussian_duality_prune_test_core #(
        .MAX_SERIES_LENGTH(MAX_LEN),
        .FRACTION_BITS(FB)
    ) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [63:0] clamp(input logic signed [129:0] x, ref bit sat);
        if (x > 130'sh7FFF_FFFF_FFFF_FFFF) begin
            sat = 1'b1;
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        if (x < -130'sh8000_0000_0000_0000) begin
            sat = 1'b1;
            return 64'sh8000_0000_0000_0000;
        end
        return x[63:0];
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] x,
                                                input logic signed [63:0] y, ref bit sat);
        logic [129:0] mx, my, p;
        mx = x < 0 ? -130'(x) : 130'(x);
        my = y < 0 ? -130'(y) : 130'(y);
        p = (mx * my + (130'd1 << (FB - 1))) >> FB;
        return clamp(((x < 0) != (y < 0)) ? -$signed(p) : $signed(p), sat);
    endfunction

    function automatic logic signed [63:0] seg_mean(input logic signed [63:0] x,
                                                    input int unsigned n);
        logic [63:0] mx;
        mx = x < 0 ? 64'd0 - 64'(x) : 64'(x);
        mx = mx / n;
        return x < 0 ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
    endfunction

    function automatic logic signed [63:0] root(input logic signed [63:0] x);
        logic [127:0] v, c;
        logic [63:0]  r;
        v = 128'(x) << FB;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = 128'(r | (64'd1 << b));
            if (c * c <= v) r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic bound_t dual_bound(input logic [gdpt_pkg::S_TDATA_W-1:0] w);
        logic [15:0]        t, i, j;
        logic signed [63:0] cs_t, cs_i, cs_j, q_i, q_j;
        logic signed [63:0] s_obj, s_gap, dq, m, g, cg, msq, mg, rhs, rad, d, a, h, r, lt, rt;
        logic signed [63:0] res;
        int unsigned        len, gap;
        bit                 sat;
        bound_t             b;
        t = w[15:0]; i = w[31:16]; j = w[47:32];
        cs_t = w[111:48]; cs_i = w[175:112]; cs_j = w[239:176];
        q_i = w[303:240]; q_j = w[367:304];
        sat = 1'b0;
        if (!(j < i && i < t) || t >= MAX_LEN) begin
            b.value = '0; b.status = gdpt_pkg::ST_BAD_ORDER;
            return b;
        end
        len = t - i; gap = i - j;
        s_obj = clamp(130'(cs_t) - 130'(cs_i), sat);
        s_gap = clamp(130'(cs_i) - 130'(cs_j), sat);
        dq = clamp(130'(q_i) - 130'(q_j), sat);
        m = seg_mean(s_obj, len);
        g = seg_mean(s_gap, gap);
        cg = seg_mean(dq, gap);
        msq = qmul(m, m, sat);
        mg = qmul(m, g, sat);
        rhs = clamp(130'(msq) - 130'(clamp(130'(mg) + 130'(mg), sat)), sat);
        if (cg <= rhs) begin
            res = clamp(130'(q_i) - 130'(clamp(130'(msq) * 130'(len), sat)), sat);
        end else begin
            rad = clamp(130'(cg) + 130'(qmul(g, g, sat)), sat);
            if (rad <= 0) begin
                b.value = '0; b.status = gdpt_pkg::ST_DEGENERATE;
                return b;
            end
            r = root(rad);
            d = clamp(130'(m) - 130'(g), sat);
            a = d < 0 ? clamp(-130'(d), sat) : d;
            h = d < 0 ? clamp(-130'(g), sat) : g;
            lt = clamp(130'(r) + 130'(h), sat);
            rt = clamp(130'(r) - 130'(h), sat);
            rt = clamp(130'(rt) - 130'(a), sat);
            rt = clamp(130'(rt) - 130'(a), sat);
            res = clamp(130'(q_i) + 130'(clamp(130'(qmul(lt, rt, sat)) * 130'(len), sat)),
                        sat);
        end
        b.value = res;
        b.status = sat ? gdpt_pkg::ST_SATURATED : gdpt_pkg::ST_OK;
        return b;
    endfunction

    function automatic logic [gdpt_pkg::S_TDATA_W-1:0] pack_word(
            input logic [15:0] t, input logic [15:0] i, input logic [15:0] j,
            input logic [63:0] cs_t, input logic [63:0] cs_i, input logic [63:0] cs_j,
            input logic [63:0] q_i, input logic [63:0] q_j);
        return {q_j, q_i, cs_j, cs_i, cs_t, j, i, t};
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    task automatic send_word(input logic [gdpt_pkg::S_TDATA_W-1:0] w);
        while (!calm && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bound_q.push_back(dual_bound(w));
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] small_q();
        logic signed [63:0] v;
        v = $signed(64'($urandom_range(32'h0FFF_FFFF)));
        v = v <<< $urandom_range(12);
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (bound_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_word(pack_word(16'd10, 16'd5, 16'd2, 64'sd100 << FB, 64'sd50 << FB,
                            64'sd20 << FB, 64'sd7 << FB, 64'sd3 << FB));
        send_word(pack_word(16'd10, 16'd5, 16'd2, 64'sd10 << FB, 64'sd5 << FB,
                            64'sd2 << FB, 64'sd900 << FB, 64'sd3 << FB));
        send_word(pack_word(16'd10, 16'd5, 16'd2, 64'sd10 << FB, 64'sd5 << FB,
                            64'sd2 << FB, -(64'sd900 << FB), 64'sd3 << FB));
        send_word(pack_word(16'd9, 16'd6, 16'd3, 64'sd9 << FB, 64'sd6 << FB, 64'sd3 << FB,
                            64'sd90 << FB, 64'sd3 << FB));
        send_word(pack_word(16'd5, 16'd5, 16'd2, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5));
        send_word(pack_word(16'd5, 16'd2, 16'd2, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5));
        send_word(pack_word(16'd5, 16'd6, 16'd2, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5));
        send_word(pack_word(16'd0, 16'd0, 16'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0));
        send_word(pack_word(16'hFFFF, 16'hFFFE, 16'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5));
        send_word(pack_word(16'hFFFF, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1, '1));
        send_word(pack_word(16'hFFFE, 16'd1, 16'd0, 64'h7FFF_FFFF_FFFF_FFFF,
                            64'h8000_0000_0000_0000,
                            64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                            64'h8000_0000_0000_0000));
        send_word(pack_word(16'd2, 16'd1, 16'd0, 64'h8000_0000_0000_0000,
                            64'h7FFF_FFFF_FFFF_FFFF,
                            64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                            64'h7FFF_FFFF_FFFF_FFFF));
        send_word(pack_word(16'd3, 16'd2, 16'd1, 64'sd4 << FB, 64'sd2 << FB, 64'd0,
                            64'sd1 << FB, 64'sd1 << FB));
        send_word(pack_word(16'hFFFE, 16'h8000, 16'd0, 64'sd1 << 50, -(64'sd1 << 50),
                            64'sd1 << 50, 64'sd1 << 40, -(64'sd1 << 40)));
        drain();
    endtask

    task automatic test_random(input int unsigned n);
        logic [15:0] t, i, j;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                send_word({$urandom(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(),
                           16'($urandom())});
            end else begin
                if ($urandom_range(3) == 0) begin
                    t = 16'($urandom_range(65535, 2));
                    i = 16'($urandom_range(t - 1, 1));
                    j = 16'($urandom_range(i - 1, 0));
                end else begin
                    j = 16'($urandom_range(40));
                    i = j + 16'($urandom_range(20, 1));
                    t = i + 16'($urandom_range(20, 1));
                end
                send_word(pack_word(t, i, j, small_q(), small_q(), small_q(),
                                    small_q(), small_q()));
            end
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_sink = 1'b1;
                repeat (400) @(posedge aclk);
                hold_sink = 1'b0;
            end
            test_random(200);
        join
        drain();
    endtask

    always @(posedge aclk) begin
        bound_t b;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (bound_q.size() == 0) begin
                    report("unexpected word", m_tdata[63:0], 64'd0);
                end else begin
                    b = bound_q.pop_front();
                    if (m_tdata[63:0] !== b.value) report("dual_value", m_tdata[63:0], b.value);
                    if (m_tdata[65:64] !== b.status)
                        report("status", m_tdata[65:64], b.status);
                end
            end
            if (hold_sink) m_tready <= 1'b0;
            else m_tready <= calm || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        calm = 1'b1;
        test_random(60);
        calm = 1'b0;
        drain();
        test_random(180);
        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
